// ===== design/ufr_pkg.sv =====
// Shared types and constants for the UART frame receiver.
package ufr_pkg;

   localparam int unsigned CsrIndexBits = 3;

   typedef enum logic [CsrIndexBits-1:0] {
      CSR_SYNC_FIRST  = 3'd0,
      CSR_SYNC_SECOND = 3'd1,
      CSR_ADDR_FIRST  = 3'd2,
      CSR_ADDR_SECOND = 3'd3,
      CSR_END_CODE    = 3'd4
   } csr_index_type;

   localparam logic [7:0] SyncFirstReset  = 8'hF7;
   localparam logic [7:0] SyncSecondReset = 8'hF8;
   localparam logic [7:0] AddrFirstReset  = 8'h01;
   localparam logic [7:0] AddrSecondReset = 8'h02;
   localparam logic [7:0] EndCodeReset    = 8'hFD;

   // Frame layout positions
   localparam int unsigned PosSyncFirst  = 0;
   localparam int unsigned PosSyncSecond = 1;
   localparam int unsigned PosLength     = 2;
   localparam int unsigned PosAddrFirst  = 3;
   localparam int unsigned PosAddrSecond = 4;
   localparam int unsigned EndOffset     = 3;

   typedef enum logic [1:0] {
      EMIT_IDLE,
      EMIT_LOAD,
      EMIT_SHOW
   } emit_state_type;

endpackage

// ===== design/uart_frame_receiver.sv =====
// Top level: UART byte deframer with sync, address, end-code and checksum checks.
// Receive: one byte per cycle when no readout runs; checks resolve in the cycle the byte is taken.
// A good frame of L+4 bytes then passes the load state (store read latency) and gives
// L+4 result beats, one per cycle when not stalled; input is stalled meanwhile.
// Reset (synchronous, active high) clears the index and loads register defaults; store is not cleared.
module uart_frame_receiver #(
   parameter int unsigned BUFFER_BYTES = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_frame_byte,
   output logic [4:0] rsp_byte_pos,
   output logic       rsp_frame_last,
   input  logic       csr_write_en,
   input  logic [ufr_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int unsigned AW = $clog2(BUFFER_BYTES);
   localparam int unsigned PW = $clog2(BUFFER_BYTES + 1);
   localparam logic [PW-1:0] WrapPos = PW'(BUFFER_BYTES);
   localparam logic [AW-1:0] PosSync1 = AW'(ufr_pkg::PosSyncFirst);
   localparam logic [AW-1:0] PosSync2 = AW'(ufr_pkg::PosSyncSecond);
   localparam logic [AW-1:0] PosLen   = AW'(ufr_pkg::PosLength);
   localparam logic [AW-1:0] PosAddr1 = AW'(ufr_pkg::PosAddrFirst);
   localparam logic [AW-1:0] PosAddr2 = AW'(ufr_pkg::PosAddrSecond);

   logic [7:0] sync_first_ff, sync_second_ff, addr_first_ff, addr_second_ff, end_code_ff;

   logic [PW-1:0] wpos_ff, wpos_in;
   logic [7:0]    len_ff, len_in;
   logic [7:0]    sum_ff, sum_in;
   logic [7:0]    prev_ff, prev_in;
   logic          addr_ok_ff, addr_ok_in;

   logic          fire;
   logic [AW-1:0] pos;
   logic [8:0]    end_pos;
   logic          at_end;
   logic          start;
   logic          busy;

   assign fire      = req_valid & ~req_stall;
   assign req_stall = busy;
   assign pos       = (wpos_ff >= WrapPos) ? '0 : wpos_ff[AW-1:0];
   assign end_pos   = {1'b0, len_ff} + 9'(ufr_pkg::EndOffset);
   assign at_end    = (9'(pos) == end_pos);

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= ufr_pkg::SyncFirstReset;
         sync_second_ff <= ufr_pkg::SyncSecondReset;
         addr_first_ff  <= ufr_pkg::AddrFirstReset;
         addr_second_ff <= ufr_pkg::AddrSecondReset;
         end_code_ff    <= ufr_pkg::EndCodeReset;
      end else if (csr_write_en) begin
         case (csr_index)
            ufr_pkg::CSR_SYNC_FIRST:  sync_first_ff  <= csr_wdata;
            ufr_pkg::CSR_SYNC_SECOND: sync_second_ff <= csr_wdata;
            ufr_pkg::CSR_ADDR_FIRST:  addr_first_ff  <= csr_wdata;
            ufr_pkg::CSR_ADDR_SECOND: addr_second_ff <= csr_wdata;
            ufr_pkg::CSR_END_CODE:    end_code_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff <= '0;
      end else begin
         wpos_ff <= wpos_in;
      end
      len_ff     <= len_in;
      sum_ff     <= sum_in;
      prev_ff    <= prev_in;
      addr_ok_ff <= addr_ok_in;
   end

   // sum_ff holds bytes 2..pos-2, prev_ff holds byte pos-1.
   always_comb begin
      wpos_in    = wpos_ff;
      len_in     = len_ff;
      sum_in     = sum_ff;
      prev_in    = prev_ff;
      addr_ok_in = addr_ok_ff;
      start      = 1'b0;
      if (fire) begin
         if (pos == PosLen) begin
            len_in  = req_rx_byte;
            sum_in  = '0;
            prev_in = req_rx_byte;
         end else if (pos > PosLen) begin
            sum_in  = sum_ff + prev_ff;
            prev_in = req_rx_byte;
         end
         if (pos == PosAddr1) addr_ok_in = (req_rx_byte == addr_first_ff);

         if (pos == PosSync1) begin
            wpos_in = (req_rx_byte == sync_first_ff) ? PW'(1) : '0;
         end else if (pos == PosSync2) begin
            wpos_in = (req_rx_byte == sync_second_ff) ? PW'(2) : '0;
         end else if (pos == PosAddr2) begin
            wpos_in = (addr_ok_ff && req_rx_byte == addr_second_ff) ? PW'(5) : '0;
         end else if (at_end) begin
            start   = (req_rx_byte == end_code_ff) && (sum_ff == prev_ff);
            wpos_in = '0;
         end else begin
            wpos_in = PW'(pos) + 1'b1;
         end
      end
   end

   ufr_frame_buffer #(
      .DEPTH     (BUFFER_BYTES),
      .ADDR_BITS (AW)
   ) u_buffer (
      .clock          (clock),
      .reset          (reset),
      .wr_en          (fire),
      .wr_addr        (pos),
      .wr_data        (req_rx_byte),
      .start          (start),
      .last_addr      (pos),
      .busy           (busy),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_byte_pos   (rsp_byte_pos),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

// ===== design/ufr_frame_buffer.sv =====
// Frame byte store with sequential readout of an accepted frame.
module ufr_frame_buffer #(
   parameter int unsigned DEPTH = 32,
   parameter int unsigned ADDR_BITS = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [7:0]           wr_data,
   input  logic                 start,
   input  logic [ADDR_BITS-1:0] last_addr,
   output logic                 busy,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_frame_byte,
   output logic [4:0]           rsp_byte_pos,
   output logic                 rsp_frame_last
);

   logic [7:0]           store_ff [DEPTH];
   logic [7:0]           rd_data_ff;
   logic [ADDR_BITS-1:0] rd_addr;

   ufr_pkg::emit_state_type state_ff, state_in;
   logic [ADDR_BITS-1:0] show_pos_ff, show_pos_in;
   logic [ADDR_BITS-1:0] last_addr_ff, last_addr_in;
   logic                 is_last;
   logic                 fire;
   logic [ADDR_BITS+4:0] pos_ext;

   assign is_last = (show_pos_ff == last_addr_ff);
   assign fire    = rsp_valid & ~rsp_stall;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ufr_pkg::EMIT_IDLE;
      end else begin
         state_ff <= state_in;
      end
      show_pos_ff  <= show_pos_in;
      last_addr_ff <= last_addr_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ufr_pkg::EMIT_IDLE: begin
            if (start) state_in = ufr_pkg::EMIT_LOAD;
         end
         ufr_pkg::EMIT_LOAD: begin
            state_in = ufr_pkg::EMIT_SHOW;
         end
         ufr_pkg::EMIT_SHOW: begin
            if (!rsp_stall && is_last) state_in = ufr_pkg::EMIT_IDLE;
         end
         default: begin
            state_in = ufr_pkg::EMIT_IDLE;
         end
      endcase
   end

   // Read address runs one ahead on each taken beat; a stall rereads the same entry.
   always_comb begin
      busy         = 1'b1;
      rsp_valid    = 1'b0;
      rd_addr      = '0;
      show_pos_in  = show_pos_ff;
      last_addr_in = last_addr_ff;
      case (state_ff)
         ufr_pkg::EMIT_IDLE: begin
            busy = 1'b0;
            if (start) last_addr_in = last_addr;
         end
         ufr_pkg::EMIT_LOAD: begin
            rd_addr     = '0;
            show_pos_in = '0;
         end
         ufr_pkg::EMIT_SHOW: begin
            rsp_valid = 1'b1;
            if (fire && !is_last) begin
               rd_addr     = show_pos_ff + 1'b1;
               show_pos_in = show_pos_ff + 1'b1;
            end else begin
               rd_addr = show_pos_ff;
            end
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   assign pos_ext        = {5'd0, show_pos_ff};
   assign rsp_frame_byte = rd_data_ff;
   assign rsp_byte_pos   = pos_ext[4:0];
   assign rsp_frame_last = is_last;

endmodule
